FILE: src/shaeng_pkg.sv
// Shared types, constants and functions of the SHA-512/SHA-384 hash engine.
`timescale 1ns / 1ps
package shaeng_pkg;

  localparam int WordBits       = 64;
  localparam int RoundCount     = 80;
  localparam int BlockWords     = 16;
  localparam int WordQueueDepth = 16;
  localparam int DigestDepth    = 8;
  localparam int Sha512Words    = 8;
  localparam int Sha384Words    = 6;

  localparam logic       REQ_BYTE   = 1'b0;
  localparam logic       REQ_FINISH = 1'b1;
  localparam logic       MODE_SHA512 = 1'b0;
  localparam logic       MODE_SHA384 = 1'b1;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [3:0] LEN_HI_WORD = 4'd14;

  // one message word on its way from front to back; last closes the message
  typedef struct packed {
    logic                last;
    logic [WordBits-1:0] word;
  } msg_beat_t;

  // one digest word on its way out
  typedef struct packed {
    logic                last;
    logic [WordBits-1:0] word;
  } dig_beat_t;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] init_hash(input logic mode, input logic [2:0] idx);
    logic [63:0] r;
    r = '0;
    if (mode == MODE_SHA384) begin
      case (idx)
        3'd0: r = 64'hcbbb9d5dc1059ed8;
        3'd1: r = 64'h629a292a367cd507;
        3'd2: r = 64'h9159015a3070dd17;
        3'd3: r = 64'h152fecd8f70e5939;
        3'd4: r = 64'h67332667ffc00b31;
        3'd5: r = 64'h8eb44a8768581511;
        3'd6: r = 64'hdb0c2e0d64f98fa7;
        3'd7: r = 64'h47b5481dbefa4fa4;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        3'd0: r = 64'h6a09e667f3bcc908;
        3'd1: r = 64'hbb67ae8584caa73b;
        3'd2: r = 64'h3c6ef372fe94f82b;
        3'd3: r = 64'ha54ff53a5f1d36f1;
        3'd4: r = 64'h510e527fade682d1;
        3'd5: r = 64'h9b05688c2b3e6c1f;
        3'd6: r = 64'h1f83d9abfb41bd6b;
        3'd7: r = 64'h5be0cd19137e2179;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] r;
    case (idx)
      7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
      7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
      7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
      7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
      7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/shaeng_fifo.sv
// Small register FIFO used for the word queue and the digest queue.
`timescale 1ns / 1ps
module shaeng_fifo #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("write into full fifo");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("fifo count out of range");
  a_not_full_and_empty: assert property (@(posedge clk) disable iff (rst) !(full && empty))
    else $error("fifo full and empty at once");

endmodule

FILE: src/shaeng_front.sv
// Front end: packs message bytes into words, pads, appends the bit length.
`timescale 1ns / 1ps
module shaeng_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic                   push,
  output logic                   full,
  input  logic                   req_type,
  input  logic [7:0]             data_byte,
  output logic                   wq_push,
  output shaeng_pkg::msg_beat_t  wq_beat,
  input  logic                   wq_full
);

  typedef enum logic [2:0] {F_BYTES, F_PAD, F_ZERO, F_LENHI, F_LENLO} state_t;

  state_t         state;
  logic [55:0]    acc;
  logic [2:0]     fill;
  logic [3:0]     wix;
  logic [127:0]   bit_len;
  logic           take;
  logic [63:0]    byte_word;
  logic [63:0]    pad_word;

  assign full      = (state != F_BYTES) || wq_full;
  assign take      = push && !full;
  assign byte_word = {acc, data_byte};
  assign pad_word  = {acc, shaeng_pkg::PAD_MARK} << {(3'd7 - fill), 3'b000};

  always_comb begin
    wq_push      = 1'b0;
    wq_beat.last = 1'b0;
    wq_beat.word = '0;
    case (state)
      F_BYTES: begin
        wq_push      = take && (req_type == shaeng_pkg::REQ_BYTE) && (fill == 3'd7);
        wq_beat.word = byte_word;
      end
      F_PAD: begin
        wq_push      = !wq_full;
        wq_beat.word = pad_word;
      end
      F_ZERO: begin
        wq_push = !wq_full && (wix != shaeng_pkg::LEN_HI_WORD);
      end
      F_LENHI: begin
        wq_push      = !wq_full;
        wq_beat.word = bit_len[127:64];
      end
      F_LENLO: begin
        wq_push      = !wq_full;
        wq_beat.last = 1'b1;
        wq_beat.word = bit_len[63:0];
      end
      default: wq_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state   <= F_BYTES;
      acc     <= '0;
      fill    <= '0;
      wix     <= '0;
      bit_len <= '0;
    end else begin
      case (state)
        F_BYTES: begin
          if (take) begin
            if (req_type == shaeng_pkg::REQ_FINISH) begin
              state <= F_PAD;
            end else begin
              bit_len <= bit_len + 128'd8;
              fill    <= fill + 1'b1;
              if (fill == 3'd7) begin
                acc <= '0;
                wix <= wix + 1'b1;
              end else begin
                acc <= byte_word[55:0];
              end
            end
          end
        end
        F_PAD: begin
          if (!wq_full) begin
            acc   <= '0;
            fill  <= '0;
            wix   <= wix + 1'b1;
            state <= F_ZERO;
          end
        end
        F_ZERO: begin
          if (wix == shaeng_pkg::LEN_HI_WORD) begin
            state <= F_LENHI;
          end else if (!wq_full) begin
            wix <= wix + 1'b1;
          end
        end
        F_LENHI: begin
          if (!wq_full) begin
            state <= F_LENLO;
          end
        end
        F_LENLO: begin
          if (!wq_full) begin
            bit_len <= '0;
            wix     <= '0;
            state   <= F_BYTES;
          end
        end
        default: state <= F_BYTES;
      endcase
    end
  end

  a_len_in_place: assert property (@(posedge clk) disable iff (rst)
    (state == F_LENHI) |-> (wix == shaeng_pkg::LEN_HI_WORD))
    else $error("length word not at word 14");
  a_pad_clears_fill: assert property (@(posedge clk) disable iff (rst)
    (state == F_ZERO) |-> (fill == '0))
    else $error("byte fill left over during padding");
  a_busy_is_full: assert property (@(posedge clk) disable iff (rst)
    (state != F_BYTES) |-> full)
    else $error("input open while padding");

endmodule

FILE: src/shaeng_back.sv
// Back end: message schedule, 80-round compression and digest output.
`timescale 1ns / 1ps
module shaeng_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic                   restart_mode,
  input  logic                   mode,
  input  shaeng_pkg::msg_beat_t  wq_beat,
  input  logic                   wq_empty,
  output logic                   wq_pop,
  output logic                   dq_push,
  output shaeng_pkg::dig_beat_t  dq_beat,
  input  logic                   dq_full
);

  typedef enum logic [1:0] {B_LOAD, B_ROUND, B_ADD, B_EMIT} state_t;

  state_t      state;
  logic [63:0] w [16];
  logic [63:0] v [8];
  logic [63:0] h [8];
  logic [6:0]  cnt;
  logic        fin;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] w_new;
  logic [2:0]  last_idx;

  assign last_idx = (mode == shaeng_pkg::MODE_SHA384) ? 3'(shaeng_pkg::Sha384Words - 1)
                                                      : 3'(shaeng_pkg::Sha512Words - 1);
  assign wq_pop       = (state == B_LOAD) && !wq_empty;
  assign dq_push      = (state == B_EMIT) && !dq_full;
  assign dq_beat.word = h[cnt[2:0]];
  assign dq_beat.last = (cnt[2:0] == last_idx);

  assign t1 = v[7] + shaeng_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shaeng_pkg::round_k(cnt) + w[0];
  assign t2 = shaeng_pkg::big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = shaeng_pkg::small_sigma1(w[14]) + w[9] + shaeng_pkg::small_sigma0(w[1]) + w[0];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= B_LOAD;
      cnt   <= '0;
      fin   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= shaeng_pkg::init_hash(rst ? shaeng_pkg::MODE_SHA512 : restart_mode, 3'(i));
      end
    end else begin
      case (state)
        B_LOAD: begin
          if (!wq_empty) begin
            for (int i = 0; i < 15; i++) begin
              w[i] <= w[i+1];
            end
            w[15] <= wq_beat.word;
            fin   <= wq_beat.last;
            if (cnt == 7'(shaeng_pkg::BlockWords - 1)) begin
              cnt <= '0;
              for (int i = 0; i < 8; i++) begin
                v[i] <= h[i];
              end
              state <= B_ROUND;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        B_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          if (cnt == 7'(shaeng_pkg::RoundCount - 1)) begin
            cnt   <= '0;
            state <= B_ADD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          state <= fin ? B_EMIT : B_LOAD;
        end
        B_EMIT: begin
          if (!dq_full) begin
            if (cnt[2:0] == last_idx) begin
              cnt <= '0;
              for (int i = 0; i < 8; i++) begin
                h[i] <= shaeng_pkg::init_hash(mode, 3'(i));
              end
              state <= B_LOAD;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROUND) |-> (cnt < 7'(shaeng_pkg::RoundCount)))
    else $error("round counter out of range");
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT) |-> (cnt[2:0] <= last_idx))
    else $error("digest index past last word");
  a_pop_in_load: assert property (@(posedge clk) disable iff (rst)
    wq_pop |-> (state == B_LOAD))
    else $error("word popped outside load");

endmodule

FILE: src/sha512_hash_engine_top.sv
// Top level of the SHA-512/SHA-384 hash engine.
`timescale 1ns / 1ps
// SHA-512 / SHA-384 hasher. Push one beat per message byte (req_type 0) or a
// finish beat (req_type 1); after a finish the engine pads the message, appends
// the 128-bit bit length and delivers 8 (SHA-512) or 6 (SHA-384) digest words,
// most significant first, with digest_last on the final one, then restarts on
// the initial hash of the current mode. The front packs bytes into 64-bit words
// at one byte per cycle while full is low and feeds a 16-word queue; the back
// loads 16 words and runs one compression round per cycle over each 128-byte
// block (16 loaded words, 80 rounds, one add step), so the byte stream runs at
// close to one beat per cycle while the queue absorbs the round time. A finish
// takes the padding words in the front, one or two blocks of compression and
// the digest words. Writing hash_mode selects the mode and restarts the
// message; write it only while the engine is idle. cfg_ready is always high.
module sha512_hash_engine_top #(
  parameter int WORD_QUEUE_DEPTH = shaeng_pkg::WordQueueDepth,
  parameter int DIGEST_DEPTH     = shaeng_pkg::DigestDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word,
  output logic        digest_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        hash_mode
);

  logic                  mode;
  logic                  restart;
  logic                  wq_push;
  logic                  wq_pop;
  logic                  wq_full;
  logic                  wq_empty;
  shaeng_pkg::msg_beat_t wq_in;
  shaeng_pkg::msg_beat_t wq_out;
  logic                  dq_push;
  logic                  dq_full;
  shaeng_pkg::dig_beat_t dq_in;
  shaeng_pkg::dig_beat_t dq_out;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready;

  // mode register; a write also restarts the message in front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= shaeng_pkg::MODE_SHA512;
    end else if (restart) begin
      mode <= hash_mode;
    end
  end

  shaeng_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .data_byte (data_byte),
    .wq_push   (wq_push),
    .wq_beat   (wq_in),
    .wq_full   (wq_full)
  );

  // word queue between front and back
  shaeng_fifo #(
    .WIDTH ($bits(shaeng_pkg::msg_beat_t)),
    .DEPTH (WORD_QUEUE_DEPTH)
  ) u_word_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wq_push),
    .wr_data (wq_in),
    .rd_en   (wq_pop),
    .rd_data (wq_out),
    .full    (wq_full),
    .empty   (wq_empty)
  );

  shaeng_back u_back (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .restart_mode (hash_mode),
    .mode         (mode),
    .wq_beat      (wq_out),
    .wq_empty     (wq_empty),
    .wq_pop       (wq_pop),
    .dq_push      (dq_push),
    .dq_beat      (dq_in),
    .dq_full      (dq_full)
  );

  // digest queue toward the result side
  shaeng_fifo #(
    .WIDTH ($bits(shaeng_pkg::dig_beat_t)),
    .DEPTH (DIGEST_DEPTH)
  ) u_digest_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (dq_push),
    .wr_data (dq_in),
    .rd_en   (pop),
    .rd_data (dq_out),
    .full    (dq_full),
    .empty   (empty)
  );

  assign digest_word = dq_out.word;
  assign digest_last = dq_out.last;

endmodule
